// ===== rtl/core/tsp_pkg.sv =====
// shared types and constants for the transport stream header parser
package tsp_pkg;

    localparam logic [7:0]  SYNC_BYTE = 8'h47;
    localparam logic [12:0] NULL_PID  = 13'h1FFF;

    typedef enum logic [1:0] {
        KIND_INFO    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_SYNC     = 3'd1,
        ERR_TEI      = 3'd2,
        ERR_RSVD     = 3'd3,
        ERR_LENGTH   = 3'd4,
        ERR_FIELD    = 3'd5,
        ERR_EXT      = 3'd6
    } t_err;

    // one-hot codes keep their packet order, so range compares still work
    typedef enum logic [16:0] {
        PH_SYNC     = 17'h00001,
        PH_H1       = 17'h00002,
        PH_H2       = 17'h00004,
        PH_H3       = 17'h00008,
        PH_AFLEN    = 17'h00010,
        PH_AFFLAGS  = 17'h00020,
        PH_PCR      = 17'h00040,
        PH_OPCR     = 17'h00080,
        PH_SPLICE   = 17'h00100,
        PH_PRIVLEN  = 17'h00200,
        PH_PRIV     = 17'h00400,
        PH_EXTLEN   = 17'h00800,
        PH_EXTFLAGS = 17'h01000,
        PH_EXTFIELD = 17'h02000,
        PH_EXTRSVD  = 17'h04000,
        PH_STUFF    = 17'h08000,
        PH_PAYLOAD  = 17'h10000
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [12:0] pid;
        logic [7:0]  data;
        logic        payload_start;
        logic        last_byte;
        logic [3:0]  continuity;
        logic [7:0]  payload_length;
        logic        pcr_valid;
        logic [32:0] pcr_base;
        logic [8:0]  pcr_ext;
        t_err        error_code;
    } t_result;

endpackage

// ===== rtl/core/ts_packet_header_parser.sv =====
// transport stream packet header parser top level
// each result is registered in the output buffer's main entry, or in its skid entry while the output stalls
// throughput: one byte per cycle; a stall on the output holds input once the skid entry fills
// each byte gives zero or one result; an error result halts the parser until reset
// reset: synchronous active-low, returns to sync search and clears the halt
module ts_packet_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_stream_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [12:0] o_pid,
    output logic [7:0]  o_data,
    output logic        o_payload_start,
    output logic        o_last_byte,
    output logic [3:0]  o_continuity,
    output logic [7:0]  o_payload_length,
    output logic        o_pcr_valid,
    output logic [32:0] o_pcr_base,
    output logic [8:0]  o_pcr_ext,
    output logic [2:0]  o_error_code
);

    tsp_pkg::t_result res, out_res;
    logic res_valid, full, accept;

    assign accept  = i_valid && !full;
    assign o_stall = full;

    tsp_parse u_parse (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(accept), .i_byte(i_stream_byte),
        .o_res_valid(res_valid), .o_res(res)
    );

    tsp_out_buf u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(res_valid), .i_res(res),
        .o_full(full), .o_valid(o_valid), .i_stall(i_stall), .o_res(out_res)
    );

    assign o_kind           = out_res.kind;
    assign o_pid            = out_res.pid;
    assign o_data           = out_res.data;
    assign o_payload_start  = out_res.payload_start;
    assign o_last_byte      = out_res.last_byte;
    assign o_continuity     = out_res.continuity;
    assign o_payload_length = out_res.payload_length;
    assign o_pcr_valid      = out_res.pcr_valid;
    assign o_pcr_base       = out_res.pcr_base;
    assign o_pcr_ext        = out_res.pcr_ext;
    assign o_error_code     = out_res.error_code;

endmodule

// ===== rtl/core/tsp_parse.sv =====
// per-byte parse state machine, one byte in and at most one result out per cycle
module tsp_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [7:0]         i_byte,
    output logic               o_res_valid,
    output tsp_pkg::t_result   o_res
);

    tsp_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_idx, n_idx;
    logic [12:0] r_pid, n_pid;
    logic [7:0]  r_hflags, n_hflags;
    logic [7:0]  r_af_rem, n_af_rem;
    logic [7:0]  r_af_flags, n_af_flags;
    logic [3:0]  r_fcnt, n_fcnt;
    logic [47:0] r_pcr, n_pcr;
    logic [7:0]  r_priv_rem, n_priv_rem;
    logic [7:0]  r_ext_rem, n_ext_rem;
    logic [2:0]  r_ext_flags, n_ext_flags;
    logic        r_halted, n_halted;

    logic           emit;
    tsp_pkg::t_kind e_kind;
    logic [7:0]     e_plen;
    logic           e_last;
    tsp_pkg::t_err  e_err;

    logic        in_af;
    logic [7:0]  af_dec;
    logic [7:0]  plen_af;
    logic [3:0]  ext_need;
    logic [2:0]  bflags;
    logic [1:0]  afc;
    logic [7:0]  ext_dec;

    always_comb begin
        in_af   = (r_phase >= tsp_pkg::PH_AFFLAGS) && (r_phase <= tsp_pkg::PH_STUFF);
        af_dec  = (in_af && r_af_rem != 8'd0) ? r_af_rem - 8'd1 : r_af_rem;
        plen_af = (r_idx < 8'd187) ? 8'd187 - r_idx : 8'd0;
        bflags  = i_byte[7:5];
        afc     = i_byte[5:4];
        ext_dec = (r_ext_rem != 8'd0) ? r_ext_rem - 8'd1 : r_ext_rem;
        ext_need = (bflags[2] ? 4'd2 : 4'd0) + (bflags[1] ? 4'd3 : 4'd0)
                 + (bflags[0] ? 4'd5 : 4'd0);
    end

    // next-state logic; the adaptation-field chain is resolved within the cycle
    always_comb begin
        logic do_ext;
        logic do_af;
        logic do_fin;
        n_phase = r_phase;   n_idx = r_idx;       n_pid = r_pid;
        n_hflags = r_hflags; n_af_rem = af_dec;   n_af_flags = r_af_flags;
        n_fcnt = r_fcnt;     n_pcr = r_pcr;       n_priv_rem = r_priv_rem;
        n_ext_rem = r_ext_rem; n_ext_flags = r_ext_flags; n_halted = r_halted;
        emit = 1'b0; e_kind = tsp_pkg::KIND_INFO; e_plen = 8'd0; e_last = 1'b0;
        e_err = tsp_pkg::ERR_NONE;
        do_ext = 1'b0; do_af = 1'b0; do_fin = 1'b0;

        if (in_af && r_phase != tsp_pkg::PH_STUFF &&
            r_phase == tsp_pkg::PH_EXTFIELD && r_ext_rem == 8'd0) begin
            emit = 1'b1; e_kind = tsp_pkg::KIND_ERROR; e_err = tsp_pkg::ERR_EXT;
        end else if (in_af && r_phase != tsp_pkg::PH_STUFF && r_af_rem == 8'd0) begin
            emit = 1'b1; e_kind = tsp_pkg::KIND_ERROR; e_err = tsp_pkg::ERR_FIELD;
        end else begin
            unique case (r_phase)
                tsp_pkg::PH_SYNC: begin
                    n_pid = '0; n_hflags = '0; n_pcr = '0;
                    if (i_byte != tsp_pkg::SYNC_BYTE) begin
                        emit = 1'b1; e_kind = tsp_pkg::KIND_ERROR; e_err = tsp_pkg::ERR_SYNC;
                    end else begin
                        n_phase = tsp_pkg::PH_H1;
                    end
                end
                tsp_pkg::PH_H1: begin
                    n_hflags = i_byte & 8'hC0;
                    n_pid = {i_byte[4:0], 8'h00};
                    n_phase = tsp_pkg::PH_H2;
                end
                tsp_pkg::PH_H2: begin
                    n_pid = r_pid | {5'd0, i_byte};
                    n_phase = tsp_pkg::PH_H3;
                end
                tsp_pkg::PH_H3: begin
                    n_hflags = {1'b0, r_hflags[6], 2'b00, i_byte[3:0]};
                    if (r_pid == tsp_pkg::NULL_PID) begin
                        n_hflags[4] = 1'b1;
                        emit = 1'b1; e_kind = tsp_pkg::KIND_INFO; e_plen = 8'd184;
                        n_phase = tsp_pkg::PH_PAYLOAD;
                    end else if (r_hflags[7]) begin
                        emit = 1'b1; e_kind = tsp_pkg::KIND_ERROR; e_err = tsp_pkg::ERR_TEI;
                    end else if (afc == 2'd0) begin
                        emit = 1'b1; e_kind = tsp_pkg::KIND_ERROR; e_err = tsp_pkg::ERR_RSVD;
                    end else begin
                        n_hflags[5:4] = afc;
                        if (afc == 2'd1) begin
                            emit = 1'b1; e_kind = tsp_pkg::KIND_INFO; e_plen = 8'd184;
                            n_phase = tsp_pkg::PH_PAYLOAD;
                        end else begin
                            n_phase = tsp_pkg::PH_AFLEN;
                        end
                    end
                end
                tsp_pkg::PH_AFLEN: begin
                    if (i_byte > 8'd183) begin
                        emit = 1'b1; e_kind = tsp_pkg::KIND_ERROR;
                        e_err = tsp_pkg::ERR_LENGTH;
                    end else if (i_byte == 8'd0) begin
                        do_fin = 1'b1;
                    end else begin
                        n_af_rem = i_byte;
                        n_phase = tsp_pkg::PH_AFFLAGS;
                    end
                end
                tsp_pkg::PH_AFFLAGS: begin
                    n_af_flags = i_byte;
                    do_af = 1'b1;
                end
                tsp_pkg::PH_PCR: begin
                    n_pcr = {r_pcr[39:0], i_byte};
                    n_fcnt = (r_fcnt != 4'd0) ? r_fcnt - 4'd1 : r_fcnt;
                    if (n_fcnt == 4'd0) begin
                        n_hflags[7] = 1'b1;
                        do_af = 1'b1;
                    end
                end
                tsp_pkg::PH_OPCR: begin
                    n_fcnt = (r_fcnt != 4'd0) ? r_fcnt - 4'd1 : r_fcnt;
                    do_af = (n_fcnt == 4'd0);
                end
                tsp_pkg::PH_SPLICE: do_af = 1'b1;
                tsp_pkg::PH_PRIVLEN: begin
                    n_priv_rem = i_byte;
                    if (i_byte == 8'd0) do_af = 1'b1;
                    else n_phase = tsp_pkg::PH_PRIV;
                end
                tsp_pkg::PH_PRIV: begin
                    n_priv_rem = (r_priv_rem != 8'd0) ? r_priv_rem - 8'd1 : r_priv_rem;
                    do_af = (n_priv_rem == 8'd0);
                end
                tsp_pkg::PH_EXTLEN: begin
                    n_ext_rem = i_byte;
                    if (i_byte == 8'd0) do_af = 1'b1;
                    else n_phase = tsp_pkg::PH_EXTFLAGS;
                end
                tsp_pkg::PH_EXTFLAGS: begin
                    n_ext_rem = ext_dec;
                    n_ext_flags = bflags;
                    if ({4'd0, ext_need} > ext_dec) begin
                        emit = 1'b1; e_kind = tsp_pkg::KIND_ERROR; e_err = tsp_pkg::ERR_EXT;
                    end else begin
                        do_ext = 1'b1;
                    end
                end
                tsp_pkg::PH_EXTFIELD: begin
                    n_ext_rem = r_ext_rem - 8'd1;
                    n_fcnt = (r_fcnt != 4'd0) ? r_fcnt - 4'd1 : r_fcnt;
                    do_ext = (n_fcnt == 4'd0);
                end
                tsp_pkg::PH_EXTRSVD: begin
                    n_ext_rem = ext_dec;
                    do_af = (n_ext_rem == 8'd0);
                end
                tsp_pkg::PH_STUFF: do_fin = (af_dec == 8'd0);
                tsp_pkg::PH_PAYLOAD: begin
                    emit = 1'b1; e_kind = tsp_pkg::KIND_PAYLOAD;
                    e_last = (r_idx >= 8'd187);
                    if (e_last) n_phase = tsp_pkg::PH_SYNC;
                end
                default: n_phase = tsp_pkg::PH_SYNC;
            endcase

            // extension field walk, falls back to the adaptation walk
            if (do_ext) begin
                priority if (n_ext_flags[2]) begin
                    n_ext_flags[2] = 1'b0; n_fcnt = 4'd2; n_phase = tsp_pkg::PH_EXTFIELD;
                end else if (n_ext_flags[1]) begin
                    n_ext_flags[1] = 1'b0; n_fcnt = 4'd3; n_phase = tsp_pkg::PH_EXTFIELD;
                end else if (n_ext_flags[0]) begin
                    n_ext_flags[0] = 1'b0; n_fcnt = 4'd5; n_phase = tsp_pkg::PH_EXTFIELD;
                end else if (n_ext_rem != 8'd0) begin
                    n_phase = tsp_pkg::PH_EXTRSVD;
                end else begin
                    do_af = 1'b1;
                end
            end
            if (do_af) begin
                priority if (n_af_flags[4]) begin
                    n_af_flags[4] = 1'b0; n_fcnt = 4'd6; n_phase = tsp_pkg::PH_PCR;
                end else if (n_af_flags[3]) begin
                    n_af_flags[3] = 1'b0; n_fcnt = 4'd6; n_phase = tsp_pkg::PH_OPCR;
                end else if (n_af_flags[2]) begin
                    n_af_flags[2] = 1'b0; n_phase = tsp_pkg::PH_SPLICE;
                end else if (n_af_flags[1]) begin
                    n_af_flags[1] = 1'b0; n_phase = tsp_pkg::PH_PRIVLEN;
                end else if (n_af_flags[0]) begin
                    n_af_flags[0] = 1'b0; n_phase = tsp_pkg::PH_EXTLEN;
                end else if (n_af_rem != 8'd0) begin
                    n_phase = tsp_pkg::PH_STUFF;
                end else begin
                    do_fin = 1'b1;
                end
            end
            if (do_fin) begin
                emit = 1'b1;
                if (n_hflags[5:4] == 2'd2 && plen_af != 8'd0) begin
                    e_kind = tsp_pkg::KIND_ERROR; e_err = tsp_pkg::ERR_LENGTH;
                end else begin
                    e_kind = tsp_pkg::KIND_INFO; e_plen = plen_af;
                    n_phase = (plen_af != 8'd0) ? tsp_pkg::PH_PAYLOAD : tsp_pkg::PH_SYNC;
                end
            end
        end

        if (e_kind == tsp_pkg::KIND_ERROR && emit) n_halted = 1'b1;
        n_idx = (n_phase == tsp_pkg::PH_SYNC) ? 8'd0 : r_idx + 8'd1;
    end

    // result fields are taken from the state as updated by this byte
    always_comb begin
        logic info;
        logic pkt;
        logic pv;
        info = (e_kind == tsp_pkg::KIND_INFO);
        pkt  = (e_kind != tsp_pkg::KIND_ERROR);
        pv   = info && n_hflags[7];
        o_res.kind           = e_kind;
        o_res.pid            = n_pid;
        o_res.data           = (e_kind == tsp_pkg::KIND_PAYLOAD) ? i_byte : 8'd0;
        o_res.payload_start  = pkt ? n_hflags[6] : 1'b0;
        o_res.last_byte      = e_last;
        o_res.continuity     = pkt ? n_hflags[3:0] : 4'd0;
        o_res.payload_length = info ? e_plen : 8'd0;
        o_res.pcr_valid      = pv;
        o_res.pcr_base       = pv ? n_pcr[47:15] : 33'd0;
        o_res.pcr_ext        = pv ? n_pcr[8:0] : 9'd0;
        o_res.error_code     = e_err;
        o_res_valid          = i_en && !r_halted && emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tsp_pkg::PH_SYNC; r_idx <= '0; r_pid <= '0; r_hflags <= '0;
            r_af_rem <= '0; r_af_flags <= '0; r_fcnt <= '0; r_pcr <= '0;
            r_priv_rem <= '0; r_ext_rem <= '0; r_ext_flags <= '0; r_halted <= 1'b0;
        end else if (i_en && !r_halted) begin
            r_halted <= n_halted;
            if (!n_halted) begin
                r_phase <= n_phase; r_idx <= n_idx; r_pid <= n_pid; r_hflags <= n_hflags;
                r_af_rem <= n_af_rem; r_af_flags <= n_af_flags; r_fcnt <= n_fcnt;
                r_pcr <= n_pcr; r_priv_rem <= n_priv_rem; r_ext_rem <= n_ext_rem;
                r_ext_flags <= n_ext_flags;
            end
        end
    end

endmodule

// ===== rtl/core/tsp_out_buf.sv =====
// two-entry skid buffer on the result side
module tsp_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tsp_pkg::t_result i_res,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output tsp_pkg::t_result o_res
);

    tsp_pkg::t_result r_main, r_skid;
    logic r_main_v, r_skid_v;
    logic take;

    assign take    = r_main_v && !i_stall;
    assign o_valid = r_main_v;
    assign o_res   = r_main;
    assign o_full  = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (!r_main_v || take) begin
                if (r_skid_v) begin
                    r_main   <= r_skid;
                    r_main_v <= 1'b1;
                    r_skid_v <= i_valid;
                    r_skid   <= i_res;
                end else begin
                    r_main   <= i_res;
                    r_main_v <= i_valid;
                end
            end else if (i_valid) begin
                r_skid   <= i_res;
                r_skid_v <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/tsp_checker.sv =====
// port-level checks for the transport stream parser
module tsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_data,
    input logic [7:0]  o_payload_length,
    input logic        o_last_byte,
    input logic [2:0]  o_error_code
);

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_kind <= tsp_pkg::KIND_ERROR) else $error("bad kind");

    a_err_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != tsp_pkg::KIND_ERROR) |-> o_error_code == tsp_pkg::ERR_NONE)
        else $error("stray error code");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == tsp_pkg::KIND_INFO) |-> o_payload_length <= 8'd184)
        else $error("length");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_byte) |-> o_kind == tsp_pkg::KIND_PAYLOAD) else $error("last flag");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data))) else $error("hold");

endmodule

bind ts_packet_header_parser tsp_checker u_tsp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_kind(o_kind), .o_data(o_data), .o_payload_length(o_payload_length),
    .o_last_byte(o_last_byte), .o_error_code(o_error_code)
);

// ===== verif/ts_packet_header_parser_tb.sv =====
// testbench for the transport stream packet header parser
module ts_packet_header_parser_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_stream_byte = 8'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [12:0] o_pid;
    logic [7:0]  o_data;
    logic        o_payload_start;
    logic        o_last_byte;
    logic [3:0]  o_continuity;
    logic [7:0]  o_payload_length;
    logic        o_pcr_valid;
    logic [32:0] o_pcr_base;
    logic [8:0]  o_pcr_ext;
    logic [2:0]  o_error_code;

    ts_packet_header_parser DUT (.*);

    always #6 i_clk = ~i_clk;

    // ---------------- packet parser prediction ----------------
    tsp_pkg::t_phase  phase;
    logic [7:0]       pkt_idx;
    logic [12:0]      pkt_pid;
    logic [7:0]       hdr_flags;
    logic [7:0]       af_left;
    logic [7:0]       af_fl;
    int               fld_left;
    logic [47:0]      pcr_sr;
    logic [7:0]       priv_left;
    logic [7:0]       ext_left;
    logic [2:0]       ext_fl;
    bit               stopped;
    tsp_pkg::t_result pred;
    bit               pred_hit;

    tsp_pkg::t_result expected_results[$];

    function automatic void emit(tsp_pkg::t_kind k, logic [7:0] d, bit last, logic [7:0] plen,
                                 tsp_pkg::t_err e);
        bit pkt;
        bit info;
        bit pv;
        pkt  = (k != tsp_pkg::KIND_ERROR);
        info = (k == tsp_pkg::KIND_INFO);
        pv   = info && hdr_flags[7];
        pred = '0;
        pred.kind           = k;
        pred.pid            = pkt_pid;
        pred.data           = d;
        pred.payload_start  = pkt ? hdr_flags[6] : 1'b0;
        pred.last_byte      = last;
        pred.continuity     = pkt ? hdr_flags[3:0] : 4'd0;
        pred.payload_length = info ? plen : 8'd0;
        pred.pcr_valid      = pv;
        pred.pcr_base       = pv ? pcr_sr[47:15] : 33'd0;
        pred.pcr_ext        = pv ? pcr_sr[8:0] : 9'd0;
        pred.error_code     = e;
        pred_hit = 1'b1;
    endfunction

    function automatic void halt(tsp_pkg::t_err e);
        stopped = 1'b1;
        emit(tsp_pkg::KIND_ERROR, 8'd0, 1'b0, 8'd0, e);
    endfunction

    function automatic void close_af(int i);
        int plen;
        plen = (i < 187) ? 187 - i : 0;
        if (hdr_flags[5:4] == 2'd2 && plen > 0) begin
            halt(tsp_pkg::ERR_LENGTH);
        end else begin
            emit(tsp_pkg::KIND_INFO, 8'd0, 1'b0, plen[7:0], tsp_pkg::ERR_NONE);
            phase = (plen != 0) ? tsp_pkg::PH_PAYLOAD : tsp_pkg::PH_SYNC;
        end
    endfunction

    function automatic void next_af(int i);
        if (af_fl[4]) begin
            af_fl[4] = 1'b0; fld_left = 6; phase = tsp_pkg::PH_PCR;
        end else if (af_fl[3]) begin
            af_fl[3] = 1'b0; fld_left = 6; phase = tsp_pkg::PH_OPCR;
        end else if (af_fl[2]) begin
            af_fl[2] = 1'b0; phase = tsp_pkg::PH_SPLICE;
        end else if (af_fl[1]) begin
            af_fl[1] = 1'b0; phase = tsp_pkg::PH_PRIVLEN;
        end else if (af_fl[0]) begin
            af_fl[0] = 1'b0; phase = tsp_pkg::PH_EXTLEN;
        end else if (af_left > 0) begin
            phase = tsp_pkg::PH_STUFF;
        end else begin
            close_af(i);
        end
    endfunction

    function automatic void next_ext(int i);
        if (ext_fl[2]) begin
            ext_fl[2] = 1'b0; fld_left = 2; phase = tsp_pkg::PH_EXTFIELD;
        end else if (ext_fl[1]) begin
            ext_fl[1] = 1'b0; fld_left = 3; phase = tsp_pkg::PH_EXTFIELD;
        end else if (ext_fl[0]) begin
            ext_fl[0] = 1'b0; fld_left = 5; phase = tsp_pkg::PH_EXTFIELD;
        end else if (ext_left > 0) begin
            phase = tsp_pkg::PH_EXTRSVD;
        end else begin
            next_af(i);
        end
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        int  i;
        int  need;
        bit  in_af;
        bit  tei;
        logic [1:0] afc;
        pred_hit = 1'b0;
        if (stopped) return;
        i = pkt_idx;
        in_af = (phase >= tsp_pkg::PH_AFFLAGS) && (phase <= tsp_pkg::PH_STUFF);
        if (in_af && phase != tsp_pkg::PH_STUFF) begin
            if (phase == tsp_pkg::PH_EXTFIELD && ext_left == 0) begin
                halt(tsp_pkg::ERR_EXT);
                return;
            end
            if (af_left == 0) begin
                halt(tsp_pkg::ERR_FIELD);
                return;
            end
        end
        if (in_af && af_left > 0) af_left--;
        case (phase)
            tsp_pkg::PH_SYNC: begin
                pkt_pid = '0; hdr_flags = '0; pcr_sr = '0;
                if (b != tsp_pkg::SYNC_BYTE) halt(tsp_pkg::ERR_SYNC);
                else phase = tsp_pkg::PH_H1;
            end
            tsp_pkg::PH_H1: begin
                hdr_flags = b & 8'hC0;
                pkt_pid = {b[4:0], 8'd0};
                phase = tsp_pkg::PH_H2;
            end
            tsp_pkg::PH_H2: begin
                pkt_pid[7:0] = b;
                phase = tsp_pkg::PH_H3;
            end
            tsp_pkg::PH_H3: begin
                tei = hdr_flags[7];
                afc = b[5:4];
                hdr_flags = (hdr_flags & 8'h40) | {4'd0, b[3:0]};
                if (pkt_pid == tsp_pkg::NULL_PID) begin
                    hdr_flags[4] = 1'b1;
                    emit(tsp_pkg::KIND_INFO, 8'd0, 1'b0, 8'd184, tsp_pkg::ERR_NONE);
                    phase = tsp_pkg::PH_PAYLOAD;
                end else if (tei) begin
                    halt(tsp_pkg::ERR_TEI);
                end else if (afc == 2'd0) begin
                    halt(tsp_pkg::ERR_RSVD);
                end else begin
                    hdr_flags[5:4] = afc;
                    if (afc == 2'd1) begin
                        emit(tsp_pkg::KIND_INFO, 8'd0, 1'b0, 8'd184, tsp_pkg::ERR_NONE);
                        phase = tsp_pkg::PH_PAYLOAD;
                    end else begin
                        phase = tsp_pkg::PH_AFLEN;
                    end
                end
            end
            tsp_pkg::PH_AFLEN: begin
                if (b > 183) halt(tsp_pkg::ERR_LENGTH);
                else if (b == 0) close_af(i);
                else begin
                    af_left = b;
                    phase = tsp_pkg::PH_AFFLAGS;
                end
            end
            tsp_pkg::PH_AFFLAGS: begin
                af_fl = b;
                next_af(i);
            end
            tsp_pkg::PH_PCR: begin
                pcr_sr = {pcr_sr[39:0], b};
                if (fld_left > 0) fld_left--;
                if (fld_left == 0) begin
                    hdr_flags[7] = 1'b1;
                    next_af(i);
                end
            end
            tsp_pkg::PH_OPCR: begin
                if (fld_left > 0) fld_left--;
                if (fld_left == 0) next_af(i);
            end
            tsp_pkg::PH_SPLICE: next_af(i);
            tsp_pkg::PH_PRIVLEN: begin
                priv_left = b;
                if (b == 0) next_af(i);
                else phase = tsp_pkg::PH_PRIV;
            end
            tsp_pkg::PH_PRIV: begin
                if (priv_left > 0) priv_left--;
                if (priv_left == 0) next_af(i);
            end
            tsp_pkg::PH_EXTLEN: begin
                ext_left = b;
                if (b == 0) next_af(i);
                else phase = tsp_pkg::PH_EXTFLAGS;
            end
            tsp_pkg::PH_EXTFLAGS: begin
                if (ext_left > 0) ext_left--;
                ext_fl = b[7:5];
                need = (ext_fl[2] ? 2 : 0) + (ext_fl[1] ? 3 : 0) + (ext_fl[0] ? 5 : 0);
                if (need > ext_left) halt(tsp_pkg::ERR_EXT);
                else next_ext(i);
            end
            tsp_pkg::PH_EXTFIELD: begin
                ext_left--;
                if (fld_left > 0) fld_left--;
                if (fld_left == 0) next_ext(i);
            end
            tsp_pkg::PH_EXTRSVD: begin
                if (ext_left > 0) ext_left--;
                if (ext_left == 0) next_af(i);
            end
            tsp_pkg::PH_STUFF: begin
                if (af_left == 0) close_af(i);
            end
            tsp_pkg::PH_PAYLOAD: begin
                emit(tsp_pkg::KIND_PAYLOAD, b, i >= 187, 8'd0, tsp_pkg::ERR_NONE);
                if (i >= 187) phase = tsp_pkg::PH_SYNC;
            end
            default: phase = tsp_pkg::PH_SYNC;
        endcase
        if (!stopped) pkt_idx = (phase == tsp_pkg::PH_SYNC) ? 8'd0 : pkt_idx + 8'd1;
    endfunction

    // ---------------- stream generation ----------------
    logic [7:0] stream_bytes[$];

    // af_len < 0 picks a fitting length, flags < 0 picks random flags
    task automatic add_packet(logic [7:0] first, logic [12:0] pid, bit tei, logic [1:0] afc,
                              int af_len, int flags);
        logic [7:0] af[$];
        logic [7:0] fl;
        logic [7:0] ef;
        int n;
        int fs;
        int r;
        int start;
        start = stream_bytes.size();
        stream_bytes.push_back(first);
        stream_bytes.push_back({tei, 1'($urandom), 1'($urandom), pid[12:8]});
        stream_bytes.push_back(pid[7:0]);
        stream_bytes.push_back({2'($urandom), afc, 4'($urandom)});
        if (afc[1] && pid != tsp_pkg::NULL_PID) begin
            fl = (flags < 0) ? 8'($urandom) : 8'(flags);
            if (af_len != 0) af.push_back(fl);
            if (af_len < 0) begin
                if (fl[4]) repeat (6) af.push_back(8'($urandom));
                if (fl[3]) repeat (6) af.push_back(8'($urandom));
                if (fl[2]) af.push_back(8'($urandom));
                if (fl[1]) begin
                    n = $urandom_range(0, 6);
                    af.push_back(8'(n));
                    repeat (n) af.push_back(8'($urandom));
                end
                if (fl[0]) begin
                    if ($urandom_range(0, 5) == 0) begin
                        af.push_back(8'd0);
                    end else begin
                        ef = 8'($urandom);
                        fs = (ef[7] ? 2 : 0) + (ef[6] ? 3 : 0) + (ef[5] ? 5 : 0);
                        r = $urandom_range(0, 2);
                        af.push_back(8'(1 + fs + r));
                        af.push_back(ef);
                        repeat (fs + r) af.push_back(8'($urandom));
                    end
                end
                if (afc == 2'd2) af_len = 183;
                else if ($urandom_range(0, 9) == 0) af_len = 183;
                else af_len = af.size() + $urandom_range(0, 8);
            end
            stream_bytes.push_back(8'(af_len));
            foreach (af[k]) stream_bytes.push_back(af[k]);
            // stuffing, content is never checked
            while (stream_bytes.size() - start < 5 + af_len && stream_bytes.size() - start < 188)
                stream_bytes.push_back(8'($urandom));
        end
        while (stream_bytes.size() - start < 188) stream_bytes.push_back(8'($urandom));
    endtask

    function automatic logic [12:0] any_pid();
        logic [12:0] p;
        p = 13'($urandom);
        if (p == tsp_pkg::NULL_PID) p = 13'd0;
        return p;
    endfunction

    // ---------------- driver, receiver, monitor ----------------
    bit  running = 1'b0;
    bit  byte_taken = 1'b0;
    bit  result_taken = 1'b0;
    int  send_gap = 0;
    int  recv_hold = 0;
    bit  no_gaps = 1'b0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  quiet_cycles = 0;

    always @(negedge i_clk) begin
        if (running) begin
            if (i_valid && !byte_taken) begin
                // hold the offered transfer
            end else if (send_gap > 0) begin
                i_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (stream_bytes.size() > 0) begin
                i_stream_byte <= stream_bytes.pop_front();
                i_valid <= 1'b1;
                if ($urandom_range(0, 60) == 0) no_gaps = ~no_gaps;
                send_gap <= no_gaps ? 0 : $urandom_range(0, 10);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (result_taken && results_seen == 150) begin
            // long hold-off so the parser backs up into its input
            recv_hold = 300;
        end else if (result_taken) begin
            recv_hold = no_gaps ? 0 : $urandom_range(0, 10);
        end
        if (recv_hold > 0) begin
            i_stall <= 1'b1;
            recv_hold--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 results_seen, field, got, want);
    endtask

    always @(posedge i_clk) begin
        tsp_pkg::t_result w;
        byte_taken   <= i_valid && !o_stall;
        result_taken <= o_valid && !i_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            parse_byte(i_stream_byte);
            if (pred_hit) expected_results.push_back(pred);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report("unexpected transfer", 64'(o_kind), 64'd0);
            end else begin
                w = expected_results.pop_front();
                if (o_kind !== w.kind) report("kind", 64'(o_kind), 64'(w.kind));
                if (o_pid !== w.pid) report("pid", 64'(o_pid), 64'(w.pid));
                if (o_data !== w.data) report("data", 64'(o_data), 64'(w.data));
                if (o_payload_start !== w.payload_start)
                    report("payload_start", 64'(o_payload_start), 64'(w.payload_start));
                if (o_last_byte !== w.last_byte)
                    report("last_byte", 64'(o_last_byte), 64'(w.last_byte));
                if (o_continuity !== w.continuity)
                    report("continuity", 64'(o_continuity), 64'(w.continuity));
                if (o_payload_length !== w.payload_length)
                    report("payload_length", 64'(o_payload_length), 64'(w.payload_length));
                if (o_pcr_valid !== w.pcr_valid)
                    report("pcr_valid", 64'(o_pcr_valid), 64'(w.pcr_valid));
                if (o_pcr_base !== w.pcr_base)
                    report("pcr_base", 64'(o_pcr_base), 64'(w.pcr_base));
                if (o_pcr_ext !== w.pcr_ext) report("pcr_ext", 64'(o_pcr_ext), 64'(w.pcr_ext));
                if (o_error_code !== w.error_code)
                    report("error_code", 64'(o_error_code), 64'(w.error_code));
            end
            results_seen++;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (running) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= 2000) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        phase = tsp_pkg::PH_SYNC; pkt_idx = '0; pkt_pid = '0; hdr_flags = '0; af_left = '0;
        af_fl = '0; fld_left = 0; pcr_sr = '0; priv_left = '0; ext_left = '0;
        ext_fl = '0; stopped = 1'b0;

        // directed packets
        add_packet(tsp_pkg::SYNC_BYTE, tsp_pkg::NULL_PID, 1'b1, 2'd0, -1, -1);
        add_packet(tsp_pkg::SYNC_BYTE, 13'h1FFE, 1'b0, 2'd2, -1, 8'hFF);
        add_packet(tsp_pkg::SYNC_BYTE, 13'h0AAA, 1'b0, 2'd3, 0, 0);
        add_packet(tsp_pkg::SYNC_BYTE, 13'h1555, 1'b0, 2'd3, 183, 8'h00);
        // random well-formed packets
        while (stream_bytes.size() < 900) begin
            if ($urandom_range(0, 5) == 0)
                add_packet(tsp_pkg::SYNC_BYTE, tsp_pkg::NULL_PID, 1'($urandom),
                           2'($urandom), -1, -1);
            else
                add_packet(tsp_pkg::SYNC_BYTE, any_pid(), 1'b0, 2'($urandom_range(1, 3)),
                           -1, -1);
        end
        // one broken packet at the end, since an error halts the parser
        case ($urandom_range(0, 6))
            0: add_packet(tsp_pkg::SYNC_BYTE ^ 8'($urandom_range(1, 255)), any_pid(), 1'b0,
                          2'd1, -1, -1);
            1: add_packet(tsp_pkg::SYNC_BYTE, any_pid(), 1'b1, 2'($urandom), -1, -1);
            2: add_packet(tsp_pkg::SYNC_BYTE, any_pid(), 1'b0, 2'd0, -1, -1);
            3: add_packet(tsp_pkg::SYNC_BYTE, any_pid(), 1'b0, 2'd3,
                          $urandom_range(184, 255), 0);
            4: add_packet(tsp_pkg::SYNC_BYTE, any_pid(), 1'b0, 2'd2,
                          $urandom_range(0, 182), 0);
            5: add_packet(tsp_pkg::SYNC_BYTE, any_pid(), 1'b0, 2'd3,
                          $urandom_range(1, 6), 8'h10);
            default: begin
                add_packet(tsp_pkg::SYNC_BYTE, any_pid(), 1'b0, 2'd3, 8, 8'h01);
                // extension length 2 with all three extension fields
                stream_bytes[stream_bytes.size() - 188 + 6] = 8'd2;
                stream_bytes[stream_bytes.size() - 188 + 7] = 8'hE0;
            end
        endcase
        repeat (20) stream_bytes.push_back(8'($urandom));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;
        while (stream_bytes.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
